[src/tcw_pkg.sv]
// Shared constants, types and helpers for the text console writer.
package tcw_pkg;

    // Screen geometry
    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int TAB_WIDTH  = 8;
    localparam int CELL_COUNT = COLUMNS * ROWS;

    localparam int ADDR_W    = $clog2(CELL_COUNT);
    localparam int COL_W     = $clog2(COLUMNS);
    localparam int COLX_W    = $clog2(COLUMNS + TAB_WIDTH);
    localparam int ROW_W     = $clog2(ROWS);
    localparam int ROWX_W    = $clog2(ROWS + 1);
    localparam int TAB_STOPS = (COLUMNS - 1) / TAB_WIDTH + 1;

    // Beat field widths
    localparam int KIND_W = 2;
    localparam int CHAR_W = 8;
    localparam int IDX_W  = 11;
    localparam int POS_W  = 11;
    localparam int DATA_W = 16;
    localparam int ATTR_W = 8;

    // Configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_SEL_TEXT_ATTR = 1'b0;

    localparam logic [ATTR_W-1:0] RESET_ATTR     = 8'h0F;
    localparam logic [CHAR_W-1:0] BLANK_CHAR     = 8'h20;
    localparam logic [CHAR_W-1:0] CODE_BACKSPACE = 8'h08;
    localparam logic [CHAR_W-1:0] CODE_TAB       = 8'h09;
    localparam logic [CHAR_W-1:0] CODE_LF        = 8'h0A;
    localparam logic [CHAR_W-1:0] CODE_CR        = 8'h0D;

    typedef enum logic [KIND_W-1:0] {
        KIND_PUT   = 2'd0,
        KIND_CLEAR = 2'd1,
        KIND_READ  = 2'd2,
        KIND_NONE  = 2'd3
    } t_kind;

    typedef struct packed {
        logic load;
        logic put;
        logic home;
        logic sweep_start;
        logic sweep_init;
        logic sweep_blank;
        logic sweep_copy;
        logic rd_issue;
        logic result;
    } t_dp_cmd;

    typedef struct packed {
        t_kind kind;
        logic  sweep_last;
        logic  need_scroll;
        logic  out_busy;
    } t_dp_stat;

    // Next tab stop after a column; compares against constant stops only.
    function automatic logic [COLX_W-1:0] next_tab(input logic [COL_W-1:0] col);
        logic [COLX_W-1:0] stop;
        stop = COLX_W'(TAB_STOPS * TAB_WIDTH);
        for (int k = TAB_STOPS; k >= 1; k--) begin
            if (k * TAB_WIDTH > int'(col)) begin
                stop = COLX_W'(k * TAB_WIDTH);
            end
        end
        return stop;
    endfunction

endpackage

[src/tcw_item_if.sv]
// Input channel: one console command per beat.
interface tcw_item_if import tcw_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [CHAR_W-1:0] char_code;
    logic [IDX_W-1:0]  cell_index;

    modport source (output valid, output kind, output char_code, output cell_index,
                    input ready);
    modport sink   (input valid, input kind, input char_code, input cell_index,
                    output ready);
endinterface

[src/tcw_result_if.sv]
// Output channel: one result per command beat.
interface tcw_result_if import tcw_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [POS_W-1:0]  cursor_position;
    logic [DATA_W-1:0] cell_data;

    modport source (output valid, output cursor_position, output cell_data, input ready);
    modport sink   (input valid, input cursor_position, input cell_data, output ready);
endinterface

[src/text_console_writer_unit.sv]
// Top level of the text console writer.
//
//  channel    direction  beat contents                          handshake
//  i_item     in         kind, char_code, cell_index            valid/ready
//  o_result   out        cursor_position, cell_data             valid/ready
//  APB        in         text_attribute at byte address 0       psel/penable
//
// A put passes through decode, execute and result load after it is accepted,
// and no new command is taken until its result is loaded; reads and unused
// kinds skip execute, and a clear sweeps the store in its place. A put that
// scrolls adds a sweep after execute. Both sweeps walk the cell store through
// its single write port, one cell a cycle. After reset the store is filled
// with blanks; no command is taken meanwhile, configuration writes are.
// A result waiting on o_result does not block the next command; that command
// holds its own result until the output register frees.
module text_console_writer_unit import tcw_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    tcw_item_if.sink           i_item,
    tcw_result_if.source       o_result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    t_dp_cmd           dp_cmd;
    t_dp_stat          dp_stat;
    logic [ATTR_W-1:0] text_attribute;
    logic              item_ready;

    tcw_apb_regs u_regs (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .o_text_attribute (text_attribute)
    );

    tcw_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (i_item.valid),
        .o_item_ready (item_ready),
        .o_cmd        (dp_cmd),
        .i_stat       (dp_stat)
    );

    tcw_datapath u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (dp_cmd),
        .o_stat            (dp_stat),
        .i_attr            (text_attribute),
        .i_kind            (i_item.kind),
        .i_char_code       (i_item.char_code),
        .i_cell_index      (i_item.cell_index),
        .i_out_ready       (o_result.ready),
        .o_out_valid       (o_result.valid),
        .o_cursor_position (o_result.cursor_position),
        .o_cell_data       (o_result.cell_data)
    );

    assign i_item.ready = item_ready;

    // One command in flight: ready drops straight after an accepted beat
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_item.valid && i_item.ready) |=> !i_item.ready)
        else $error("input accepted twice in a row");

    a_sweep_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (dp_cmd.sweep_blank || dp_cmd.sweep_copy) |-> !i_item.ready)
        else $error("input ready during a store sweep");

    a_no_result_mid_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (dp_cmd.sweep_blank || dp_cmd.sweep_copy) |-> !dp_cmd.result)
        else $error("result loaded before sweep finished");

endmodule

[src/tcw_apb_regs.sv]
// APB register file holding the text attribute.
module tcw_apb_regs import tcw_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output logic [ATTR_W-1:0]  o_text_attribute
);

    logic [ATTR_W-1:0] r_attr;
    logic              sel_attr;

    assign sel_attr = (paddr[2] == REG_SEL_TEXT_ATTR);
    assign pready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr <= RESET_ATTR;
        end else if (psel && penable && pwrite && sel_attr) begin
            r_attr <= pwdata[ATTR_W-1:0];
        end
    end

    assign prdata           = sel_attr ? PDATA_W'(r_attr) : '0;
    assign o_text_attribute = r_attr;

endmodule

[src/tcw_datapath.sv]
// Datapath: cell store, cursor, sweep pointer and result register.
module tcw_datapath import tcw_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    output t_dp_stat          o_stat,
    input  logic [ATTR_W-1:0] i_attr,
    input  logic [KIND_W-1:0] i_kind,
    input  logic [CHAR_W-1:0] i_char_code,
    input  logic [IDX_W-1:0]  i_cell_index,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output logic [POS_W-1:0]  o_cursor_position,
    output logic [DATA_W-1:0] o_cell_data
);

    logic [DATA_W-1:0] mem [CELL_COUNT];

    t_kind             r_kind;
    logic [CHAR_W-1:0] r_code;
    logic [IDX_W-1:0]  r_idx;
    logic [COL_W-1:0]  r_col;
    logic [ROW_W-1:0]  r_row;
    logic [ADDR_W-1:0] r_ptr;
    logic              r_wvalid;
    logic              r_wblank;
    logic [ADDR_W-1:0] r_wptr;
    logic [DATA_W-1:0] r_wfill;
    logic [DATA_W-1:0] r_rdata;
    logic              r_out_valid;
    logic [POS_W-1:0]  r_out_pos;
    logic [DATA_W-1:0] r_out_data;

    logic [COLX_W-1:0] col_step;
    logic [ROWX_W-1:0] row_step;
    logic [ROWX_W-1:0] row_fin;
    logic              wrap;
    logic              wr_char;
    logic              need_scroll;
    logic [COL_W-1:0]  n_col;
    logic [ROW_W-1:0]  n_row;
    logic [ADDR_W-1:0] cursor_addr;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_wa;
    logic [DATA_W-1:0] mem_wd;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              sweep;
    logic              in_range;

    // Cursor movement for a put-character beat
    always_comb begin
        row_step = ROWX_W'(r_row);
        wr_char  = 1'b0;
        unique case (r_code)
            CODE_BACKSPACE: col_step = (r_col == '0) ? '0 : COLX_W'(r_col) - 1'b1;
            CODE_TAB:       col_step = next_tab(r_col);
            CODE_CR:        col_step = '0;
            CODE_LF: begin
                col_step = '0;
                row_step = ROWX_W'(r_row) + 1'b1;
            end
            default: begin
                col_step = COLX_W'(r_col) + 1'b1;
                wr_char  = 1'b1;
            end
        endcase
        wrap        = (col_step >= COLX_W'(COLUMNS));
        row_fin     = wrap ? row_step + 1'b1 : row_step;
        need_scroll = (row_fin == ROWX_W'(ROWS));
        n_col       = wrap ? '0 : COL_W'(col_step);
        n_row       = need_scroll ? ROW_W'(ROWS - 1) : ROW_W'(row_fin);
    end

    assign cursor_addr = ADDR_W'(r_row) * ADDR_W'(COLUMNS) + ADDR_W'(r_col);
    assign sweep       = i_cmd.sweep_blank | i_cmd.sweep_copy;
    assign in_range    = (32'(r_idx) < CELL_COUNT);

    // Sweep writes drain in the cycle after their reads; a put never overlaps them.
    assign mem_we  = r_wvalid | (i_cmd.put & wr_char);
    assign mem_wa  = r_wvalid ? r_wptr : cursor_addr;
    assign mem_wd  = r_wvalid ? (r_wblank ? r_wfill : r_rdata) : {i_attr, r_code};
    assign rd_en   = i_cmd.rd_issue | i_cmd.sweep_copy;
    assign rd_addr = i_cmd.sweep_copy ? r_ptr + ADDR_W'(COLUMNS) : ADDR_W'(r_idx);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_row       <= '0;
            r_ptr       <= '0;
            r_wvalid    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.put) begin
                r_col <= n_col;
                r_row <= n_row;
            end else if (i_cmd.home) begin
                r_col <= '0;
                r_row <= '0;
            end
            r_wvalid <= sweep;
            if (i_cmd.sweep_start) begin
                r_ptr <= '0;
            end else if (sweep) begin
                r_ptr <= r_ptr + 1'b1;
            end
            if (i_cmd.result) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= t_kind'(i_kind);
            r_code <= i_char_code;
            r_idx  <= i_cell_index;
        end
        if (sweep) begin
            r_wptr   <= r_ptr;
            // Bottom row of a scroll takes blanks instead of copied cells
            r_wblank <= i_cmd.sweep_blank | (r_ptr >= ADDR_W'(CELL_COUNT - COLUMNS));
            r_wfill  <= i_cmd.sweep_init ? {RESET_ATTR, BLANK_CHAR} : {i_attr, BLANK_CHAR};
        end
        if (i_cmd.result) begin
            r_out_pos  <= POS_W'(cursor_addr);
            r_out_data <= (r_kind == KIND_READ && in_range) ? r_rdata : '0;
        end
    end

    assign o_stat.kind        = r_kind;
    assign o_stat.sweep_last  = (r_ptr == ADDR_W'(CELL_COUNT - 1));
    assign o_stat.need_scroll = need_scroll;
    assign o_stat.out_busy    = r_out_valid & ~i_out_ready;

    assign o_out_valid       = r_out_valid;
    assign o_cursor_position = r_out_pos;
    assign o_cell_data       = r_out_data;

endmodule

[src/tcw_ctrl.sv]
// Controller: sequences each command beat and the store sweeps.
module tcw_ctrl import tcw_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_item_valid,
    output logic     o_item_ready,
    output t_dp_cmd  o_cmd,
    input  t_dp_stat i_stat
);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_DECODE,
        S_PUT,
        S_SWEEP_CLR,
        S_SWEEP_SCR,
        S_DONE
    } t_state;

    t_state r_state;
    logic   r_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_ready <= 1'b0;
        end else begin
            unique case (r_state)
                S_INIT: if (i_stat.sweep_last) begin
                    r_state <= S_IDLE;
                    r_ready <= 1'b1;
                end
                S_IDLE: if (i_item_valid) begin
                    r_state <= S_DECODE;
                    r_ready <= 1'b0;
                end
                S_DECODE: begin
                    unique case (i_stat.kind)
                        KIND_PUT:   r_state <= S_PUT;
                        KIND_CLEAR: r_state <= S_SWEEP_CLR;
                        default:    r_state <= S_DONE;
                    endcase
                end
                S_PUT: r_state <= i_stat.need_scroll ? S_SWEEP_SCR : S_DONE;
                S_SWEEP_CLR, S_SWEEP_SCR: if (i_stat.sweep_last) begin
                    r_state <= S_DONE;
                end
                S_DONE: if (!i_stat.out_busy) begin
                    r_state <= S_IDLE;
                    r_ready <= 1'b1;
                end
                default: begin
                    r_state <= S_IDLE;
                    r_ready <= 1'b1;
                end
            endcase
        end
    end

    always_comb begin
        o_cmd             = '0;
        o_cmd.load        = (r_state == S_IDLE) && i_item_valid && r_ready;
        o_cmd.put         = (r_state == S_PUT);
        o_cmd.home        = (r_state == S_DECODE) && (i_stat.kind == KIND_CLEAR);
        o_cmd.sweep_start = o_cmd.home || ((r_state == S_PUT) && i_stat.need_scroll);
        o_cmd.sweep_init  = (r_state == S_INIT);
        o_cmd.sweep_blank = (r_state == S_INIT) || (r_state == S_SWEEP_CLR);
        o_cmd.sweep_copy  = (r_state == S_SWEEP_SCR);
        o_cmd.rd_issue    = (r_state == S_DECODE) && (i_stat.kind == KIND_READ);
        o_cmd.result      = (r_state == S_DONE) && !i_stat.out_busy;
    end

    assign o_item_ready = r_ready;

endmodule
